/* hw/rtl/tla_pkg.sv */
package tla_pkg;

    // Character codes used by the escaper.
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_AT     = 8'd64;
    localparam logic [7:0] CH_QMARK  = 8'd63;
    localparam logic [7:0] CH_CARET  = 8'd94;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_I      = 8'd73;
    localparam logic [7:0] CH_ZERO   = 8'd48;

    // Line counter: six BCD digits, saturating.
    localparam int unsigned  DIGITS    = 6;
    localparam logic [23:0]  COUNT_MAX = 24'h999999;

    // Numbering modes.
    localparam logic [1:0] NUM_OFF      = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_NUMBER_MODE   = 3'd0,
        CFG_SHOW_ENDS     = 3'd1,
        CFG_SHOW_TABS     = 3'd2,
        CFG_SQUEEZE_EN    = 3'd3,
        CFG_SHOW_NONPRINT = 3'd4
    } t_cfg_idx;

    // Expansion phases of one request in the back end.
    localparam logic [3:0] PH_SPACE0 = 4'd6;
    localparam logic [3:0] PH_BODY0  = 4'd8;
    localparam logic [3:0] PH_BODY1  = 4'd9;

    // Queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] number_mode;
        logic       show_ends;
        logic       show_tabs;
        logic       squeeze_en;
        logic       show_nonprint;
    } t_cfg;

    // One classified request: optional line number prefix plus one or two body bytes.
    typedef struct packed {
        logic        num_en;
        logic [23:0] count;
        logic        two_byte;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
    } t_cmd;

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

    // BCD increment with saturation at 999999.
    function automatic logic [23:0] bcd_inc(input logic [23:0] v);
        logic [23:0] res;
        logic        carry;
        logic [3:0]  d;
        res   = v;
        carry = 1'b1;
        if (v != COUNT_MAX) begin
            for (int i = 0; i < DIGITS; i++) begin
                d = v[4*i +: 4];
                if (carry) begin
                    if (d >= 4'd9) begin
                        d = 4'd0;
                    end else begin
                        d     = d + 4'd1;
                        carry = 1'b0;
                    end
                end
                res[4*i +: 4] = d;
            end
        end
        return res;
    endfunction

endpackage

/* hw/rtl/tla_front.sv */
module tla_front import tla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_file_start,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [23:0] r_line_count, n_line_count;
    logic        r_at_line_start, n_at_line_start;
    logic        r_prev_blank, n_prev_blank;

    logic        accept;
    logic        at_start;
    logic        prev_blank;
    logic [23:0] count;
    logic        blank;
    logic        squeeze;
    logic        num_en;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // A file start clears the line state before the byte is looked at.
    assign at_start   = r_at_line_start || i_file_start;
    assign prev_blank = i_file_start ? 1'b0 : r_prev_blank;
    assign count      = i_file_start ? '0 : r_line_count;

    assign blank   = (i_in_byte == CH_NL);
    assign squeeze = at_start && i_cfg.squeeze_en && blank && prev_blank;
    assign num_en  = at_start && !squeeze &&
                     ((i_cfg.number_mode == NUM_ALL) ||
                      ((i_cfg.number_mode == NUM_NONBLANK) && !blank));

    // Classify the byte into a request for the back end.
    always_comb begin
        o_cmd          = '0;
        o_cmd.num_en   = num_en;
        o_cmd.count    = num_en ? bcd_inc(count) : count;
        o_cmd.byte0    = i_in_byte;
        o_cmd.byte1    = i_in_byte;
        o_cmd.two_byte = 1'b0;
        if (blank) begin
            if (i_cfg.show_ends) begin
                o_cmd.byte0    = CH_DOLLAR;
                o_cmd.two_byte = 1'b1;
            end
        end else if ((i_in_byte == CH_TAB) && i_cfg.show_tabs) begin
            o_cmd.byte0    = CH_CARET;
            o_cmd.byte1    = CH_I;
            o_cmd.two_byte = 1'b1;
        end else if (i_cfg.show_nonprint && (i_in_byte != CH_TAB) &&
                     ((i_in_byte < CH_SPACE) || (i_in_byte == CH_DEL))) begin
            o_cmd.byte0    = CH_CARET;
            o_cmd.byte1    = (i_in_byte == CH_DEL) ? CH_QMARK : (i_in_byte + CH_AT);
            o_cmd.two_byte = 1'b1;
        end
    end

    // A squeezed blank line produces nothing.
    assign o_push = accept && !squeeze;

    // Next line state.
    always_comb begin
        n_line_count    = o_cmd.count;
        n_at_line_start = squeeze ? 1'b1 : blank;
        n_prev_blank    = at_start ? blank : prev_blank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count    <= '0;
            r_at_line_start <= 1'b1;
            r_prev_blank    <= 1'b0;
        end else if (accept) begin
            r_line_count    <= n_line_count;
            r_at_line_start <= n_at_line_start;
            r_prev_blank    <= n_prev_blank;
        end
    end

endmodule

/* hw/rtl/tla_queue.sv */
module tla_queue import tla_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_q_sts o_sts
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_sts.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_sts.empty = (r_count == '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    // Storage for queued requests.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/tla_back.sv */
module tla_back import tla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_q_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic [3:0] r_phase;
    logic       r_valid;
    logic [7:0] r_out_byte;
    logic       r_last;

    logic [3:0] phase;
    logic       last;
    logic       load;
    logic [7:0] byte_sel;
    logic [2:0] digit_idx;
    logic [3:0] digit;
    logic [DIGITS-1:0] lead_zero;

    // Without a number prefix the request starts at its body.
    assign phase = (!i_cmd.num_en && (r_phase < PH_BODY0)) ? PH_BODY0 : r_phase;
    assign last  = (phase == PH_BODY1) || ((phase == PH_BODY0) && !i_cmd.two_byte);
    assign load  = !i_q_empty && (!r_valid || i_ready);
    assign o_pop = load && last;

    // Leading-zero flags, most significant digit first.
    always_comb begin
        lead_zero[DIGITS-1] = (i_cmd.count[4*(DIGITS-1) +: 4] == 4'd0);
        for (int i = DIGITS - 2; i >= 0; i--) begin
            lead_zero[i] = lead_zero[i+1] && (i_cmd.count[4*i +: 4] == 4'd0);
        end
    end

    assign digit_idx = 3'(DIGITS - 1) - phase[2:0];

    // Pick the byte for the current phase.
    always_comb begin
        digit    = i_cmd.count[4*digit_idx +: 4];
        byte_sel = CH_SPACE;
        if (digit > 4'd9) begin
            digit = 4'd9;
        end
        if (phase < PH_SPACE0) begin
            if (lead_zero[digit_idx] && (digit_idx != 3'd0)) begin
                byte_sel = CH_SPACE;
            end else begin
                byte_sel = CH_ZERO | {4'd0, digit};
            end
        end else if (phase == PH_BODY0) begin
            byte_sel = i_cmd.byte0;
        end else if (phase == PH_BODY1) begin
            byte_sel = i_cmd.byte1;
        end
    end

    // Phase counter and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= last ? 4'd0 : (phase + 4'd1);
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= byte_sel;
            r_last     <= last;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_last;

endmodule

/* hw/rtl/text_line_annotator_core.sv */
// A request is stored in the queue before its bytes reach the back end's output register.
// Throughput: one input per cycle while the queue has room; one output byte per cycle while
// the receiver is ready, set by the back end, so a numbered line start costs up to ten bytes.
// A four-entry queue between front and back absorbs those bursts.
// Reset (synchronous, active low) clears configuration, line state, queue and output register.
module text_line_annotator_core import tla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_file_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    t_cfg   r_cfg;
    t_cmd   push_cmd, head_cmd;
    t_q_sts q_sts;
    logic   q_push, q_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUMBER_MODE:   r_cfg.number_mode   <= i_cfg_data;
                CFG_SHOW_ENDS:     r_cfg.show_ends     <= i_cfg_data[0];
                CFG_SHOW_TABS:     r_cfg.show_tabs     <= i_cfg_data[0];
                CFG_SQUEEZE_EN:    r_cfg.squeeze_en    <= i_cfg_data[0];
                CFG_SHOW_NONPRINT: r_cfg.show_nonprint <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tla_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .i_q_full     (q_sts.full),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    tla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_sts   (q_sts)
    );

    tla_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_q_empty     (q_sts.empty),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    // The queue never takes a request while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_sts.full)
        else $error("request pushed into a full queue");

    // A request is only retired from a non-empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_sts.empty)
        else $error("request popped from an empty queue");

    // New output data only comes from a queued request.
    a_out_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!q_sts.empty))
        else $error("output became valid with nothing queued");

endmodule

/* tb/sv/annotation_checker.sv */
module annotation_checker import tla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_file_start,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_last_of_run,
    input  logic       i_flush_check,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_NUM_MAX = 999999;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } t_text_out;

    // Output bytes still owed by the block, oldest first.
    t_text_out expected_text[$];
    int        mismatch_count = 0;

    // Shadow configuration.
    logic [1:0] number_mode;
    logic       show_ends;
    logic       show_tabs;
    logic       squeeze_en;
    logic       show_nonprint;

    // Shadow line state; the line number is kept as a plain integer.
    int unsigned line_num;
    logic        at_line_start;
    logic        prev_blank;
    logic        flushed;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Works out the output run of one input byte and queues it.
    task automatic annotate_byte(input logic [7:0] b, input logic fs);
        logic [7:0]  run [10];
        int          n;
        int          k;
        int unsigned scale;
        int unsigned digit;
        logic        leading;
        logic        blank;
        t_text_out   item;
        n = 0;
        blank = (b == CH_NL);
        if (fs) begin
            line_num      = 0;
            at_line_start = 1'b1;
            prev_blank    = 1'b0;
        end
        if (at_line_start) begin
            // A blank line right after a kept blank line is dropped whole.
            if (squeeze_en && blank && prev_blank) begin
                return;
            end
            prev_blank = blank;
            if (number_mode == NUM_ALL || (number_mode == NUM_NONBLANK && !blank)) begin
                if (line_num < LINE_NUM_MAX) begin
                    line_num++;
                end
                // Six columns, right aligned, leading zeros shown as spaces.
                scale   = 100000;
                leading = 1'b1;
                for (k = 0; k < 6; k++) begin
                    digit = (line_num / scale) % 10;
                    if (leading && digit == 0 && scale > 1) begin
                        run[n] = CH_SPACE;
                    end else begin
                        leading = 1'b0;
                        run[n]  = CH_ZERO + 8'(digit);
                    end
                    n++;
                    scale = scale / 10;
                end
                run[n] = CH_SPACE;
                n++;
                run[n] = CH_SPACE;
                n++;
            end
            at_line_start = 1'b0;
        end

        // The byte itself, escaped as the flags ask.
        if (blank) begin
            if (show_ends) begin
                run[n] = CH_DOLLAR;
                n++;
            end
            run[n] = CH_NL;
            n++;
            at_line_start = 1'b1;
        end else if (b == CH_TAB && show_tabs) begin
            run[n] = CH_CARET;
            run[n + 1] = CH_I;
            n += 2;
        end else if (show_nonprint && b != CH_TAB && (b < CH_SPACE || b == CH_DEL)) begin
            run[n] = CH_CARET;
            run[n + 1] = (b == CH_DEL) ? CH_QMARK : b + CH_AT;
            n += 2;
        end else begin
            run[n] = b;
            n++;
        end

        for (k = 0; k < n; k++) begin
            item.text = run[k];
            item.last = (k == n - 1);
            expected_text.push_back(item);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_text_out want;
        if (!i_rst_n) begin
            number_mode   = NUM_OFF;
            show_ends     = 1'b0;
            show_tabs     = 1'b0;
            squeeze_en    = 1'b0;
            show_nonprint = 1'b0;
            line_num      = 0;
            at_line_start = 1'b1;
            prev_blank    = 1'b0;
            flushed       = 1'b0;
            expected_text.delete();
        end else begin
            // Register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUMBER_MODE: begin
                        number_mode = i_cfg_data;
                    end
                    CFG_SHOW_ENDS: begin
                        show_ends = i_cfg_data[0];
                    end
                    CFG_SHOW_TABS: begin
                        show_tabs = i_cfg_data[0];
                    end
                    CFG_SQUEEZE_EN: begin
                        squeeze_en = i_cfg_data[0];
                    end
                    CFG_SHOW_NONPRINT: begin
                        show_nonprint = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            // Accepted input requests extend the expected stream.
            if (i_in_valid && i_in_ready) begin
                annotate_byte(i_in_byte, i_file_start);
            end

            // Accepted output requests are compared with the oldest expectation.
            if (i_out_valid && i_out_ready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte %02h", i_out_byte));
                end else begin
                    want = expected_text.pop_front();
                    if (i_out_byte !== want.text) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_out_byte, want.text));
                    end
                    if (i_last_of_run !== want.last) begin
                        report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                                  i_last_of_run, want.last, want.text));
                    end
                end
            end

            if (i_flush_check && !flushed) begin
                flushed = 1'b1;
                if (expected_text.size() != 0) begin
                    report_mismatch($sformatf("%0d output bytes never arrived",
                                              expected_text.size()));
                end
            end
        end
        o_pending = expected_text.size();
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tla_pkg::*;

    localparam int         CLK_PERIOD      = 10;
    localparam int         RESET_CYCLES    = 5;
    localparam int         RANDOM_ITEMS    = 330;
    localparam int         RANDOM_PHASES   = 6;
    localparam int         HOLD_OFF_CYCLES = 150;
    localparam int         DRAIN_LIMIT     = 5000;
    localparam int         TAIL_CYCLES     = 20;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam logic [1:0] NUM_SPARE       = 2'd3;
    localparam logic [2:0] CFG_SPARE_IDX   = 3'd5;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [1:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       file_start;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       flush_check;

    int fail_count;
    int pending_results;
    int items_sent    = 0;
    int cycle_count   = 0;
    int hold_off_reqs = 0;
    int hold_off_done = 0;
    bit idle_en       = 1'b1;

    text_line_annotator_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_in_byte     (in_byte),
        .i_file_start  (file_start),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_out_byte    (out_byte),
        .o_last_of_run (last_of_run)
    );

    annotation_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_byte     (in_byte),
        .i_file_start  (file_start),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_byte    (out_byte),
        .i_last_of_run (last_of_run),
        .i_flush_check (flush_check),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Text-like byte mix: printable, tabs, control bytes, delete and high bytes.
    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 8'($urandom_range(32, 126));
        end else if (r < 70) begin
            return CH_TAB;
        end else if (r < 80) begin
            return 8'($urandom_range(0, 31));
        end else if (r < 85) begin
            return CH_DEL;
        end
        return 8'($urandom_range(128, 255));
    endfunction

    // Output side: random stalls, plus a long hold-off on request.
    initial begin : receiver
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_reqs != hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_done++;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat (gap_cycles()) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one input request and holds it until accepted; entered at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = idle_en ? gap_cycles() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        file_start <= fs;
        do begin
            @(posedge clk);
        end while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Stops offering input and waits until every expected byte has come out.
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results != 0 && guard < DRAIN_LIMIT) begin
            @(negedge clk);
            guard++;
        end
        // A squeezed line causes no output but may still be in flight.
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        @(negedge clk);
    endtask

    // Writes all registers while the block is idle.
    task automatic set_config(input logic [1:0] mode, input logic [1:0] ends,
                              input logic [1:0] tabs, input logic [1:0] squeeze,
                              input logic [1:0] nonprint, input bit spare);
        wait_drained();
        if (spare) begin
            write_reg(CFG_SPARE_IDX, 2'($urandom_range(0, 3)));
        end
        write_reg(CFG_NUMBER_MODE, mode);
        write_reg(CFG_SHOW_ENDS, ends);
        write_reg(CFG_SHOW_TABS, tabs);
        write_reg(CFG_SQUEEZE_EN, squeeze);
        write_reg(CFG_SHOW_NONPRINT, nonprint);
        cfg_valid <= 1'b0;
    endtask

    // Mostly whole lines with random content; the rest raw noise.
    task automatic send_random_chunk();
        int   r;
        int   len;
        int   k;
        logic fs;
        r = $urandom_range(0, 99);
        if (r < 88) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                len = 0;
            end else if (r < 90) begin
                len = $urandom_range(1, 6);
            end else begin
                len = $urandom_range(7, 20);
            end
            fs = ($urandom_range(0, 19) == 0);
            for (k = 0; k < len; k++) begin
                send_byte(random_text_byte(), fs && k == 0);
            end
            send_byte(CH_NL, fs && len == 0);
        end else begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        int target;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_NUMBER_MODE;
        cfg_data    = 2'b00;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        file_start  = 1'b0;
        flush_check = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: everything passes through, tab and control bytes too.
        send_byte(8'h61, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(CH_NL, 1'b0);

        // Every flag on: numbering, escapes, high bytes and squeezed blank lines.
        set_config(NUM_ALL, 2'd1, 2'd1, 2'd1, 2'd1, 1'b0);
        send_byte(8'h78, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(CH_NL, 1'b0);

        // Non-blank numbering; tab and newline pass unchanged under nonprint alone.
        set_config(NUM_NONBLANK, 2'd0, 2'd0, 2'd0, 2'd1, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(CH_NL, 1'b0);

        // The unused numbering mode behaves as no numbering.
        set_config(NUM_SPARE, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(CH_NL, 1'b0);

        // Random phases, each under its own settings.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    set_config(NUM_OFF, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0);
                end
                1: begin
                    set_config(NUM_ALL, 2'd1, 2'd1, 2'd1, 2'd1, 1'b0);
                end
                2: begin
                    set_config(NUM_NONBLANK, 2'd1, 2'd1, 2'd1, 2'd1, 1'b1);
                end
                3: begin
                    set_config(NUM_SPARE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0);
                end
                default: begin
                    set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               2'($urandom_range(0, 3)), 1'b1);
                end
            endcase
            // One phase runs with no idle gaps: input always offered and output always ready.
            idle_en = (phase != 1);
            // One phase starts with the output side held off while input keeps coming.
            if (phase == 2) begin
                hold_off_reqs++;
            end
            target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < target) begin
                send_random_chunk();
            end
        end

        wait_drained();
        flush_check <= 1'b1;
        repeat (2) @(negedge clk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
